// ----- rtl/ranicp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ranicp_pkg
// Shared constants for the animated-cursor RIFF chunk parser: well-known
// chunk ids, the byte classification codes and the register map.
// ----------------------------------------------------------------------------
package ranicp_pkg;

  localparam int unsigned TagW   = 32;
  localparam int unsigned CntW   = 34;
  localparam int unsigned RemW   = 33;
  localparam int unsigned KindW  = 3;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned ApbDw  = 32;
  localparam int unsigned ApbAw  = 3;

  // little-endian four-character codes
  localparam logic [TagW-1:0] TagRiff = 32'h4646_4952;
  localparam logic [TagW-1:0] TagAcon = 32'h4E4F_4341;
  localparam logic [TagW-1:0] TagList = 32'h5453_494C;
  localparam logic [TagW-1:0] TagIcon = 32'h6E6F_6369;

  // header bytes not covered by the riff length field
  localparam logic [CntW-1:0] HdrExtra = 34'd8;
  localparam logic [CntW-1:0] CntMax   = {CntW{1'b1}};

  // register index of target_id (address bit 2 selects the word)
  localparam logic RegTargetId = 1'b0;

  // byte classification
  localparam logic [KindW-1:0] KindHeader   = 3'd0;
  localparam logic [KindW-1:0] KindChunkId  = 3'd1;
  localparam logic [KindW-1:0] KindListSkip = 3'd2;
  localparam logic [KindW-1:0] KindSize     = 3'd3;
  localparam logic [KindW-1:0] KindPayload  = 3'd4;
  localparam logic [KindW-1:0] KindPastEnd  = 3'd5;
  localparam logic [KindW-1:0] KindRejected = 3'd6;

endpackage
`default_nettype wire

// ----- rtl/ranicp_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ranicp_regs
// APB register file holding the target chunk id; writes land on the access
// cycle, reads return the register, pready is tied high.
// ----------------------------------------------------------------------------
module ranicp_regs (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [ranicp_pkg::ApbAw-1:0]   paddr,
  input  wire  [ranicp_pkg::ApbDw-1:0]   pwdata,
  output logic [ranicp_pkg::ApbDw-1:0]   prdata,
  output logic                           pready,
  output logic [ranicp_pkg::TagW-1:0]    target_id_o
);

  logic [ranicp_pkg::TagW-1:0] target_id_q;
  logic                        sel_target;

  assign pready     = 1'b1;
  assign sel_target = (paddr[2] == ranicp_pkg::RegTargetId);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q <= ranicp_pkg::TagIcon;
    end else if (psel && penable && pwrite && pready && sel_target) begin
      target_id_q <= pwdata[ranicp_pkg::TagW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_target) begin
      prdata = target_id_q;
    end
  end

  assign target_id_o = target_id_q;

endmodule
`default_nettype wire

// ----- rtl/riff_ani_chunk_parser_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// riff_ani_chunk_parser_core
// Byte-wide RIFF/ACON chunk parser: classifies each byte, tags payload with
// its chunk id and flags the first chunk matching the target id.
// ----------------------------------------------------------------------------
// result: registered, valid on the master side in the cycle after the input transfer
// throughput: one byte per cycle; the single parse-state update per byte and
//   one output register set the figure, stalls only when the output is held
// reset: async active low; parser returns to expecting 'RIFF', counters and
//   ids clear, target id returns to 'icon', output register empties
// ----------------------------------------------------------------------------
module riff_ani_chunk_parser_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // slave side
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire  [7:0]                     s_axis_tdata_i,   // [7:0] data_byte
  input  wire                            s_axis_tuser_i,   // [0] start_of_file
  // master side
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [39:0]                    m_axis_tdata_o,   // [31:0] chunk_tag, [39:32] payload_byte
  output logic [3:0]                     m_axis_tuser_o,   // [2:0] byte_kind, [3] target_hit
  output logic                           m_axis_tlast_o,   // chunk_last
  // configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [ranicp_pkg::ApbAw-1:0]   paddr,
  input  wire  [ranicp_pkg::ApbDw-1:0]   pwdata,
  output logic [ranicp_pkg::ApbDw-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned PW = ranicp_pkg::PhaseW;
  localparam logic [PW-1:0] PhRiff      = 4'd0;
  localparam logic [PW-1:0] PhLen       = 4'd1;
  localparam logic [PW-1:0] PhAcon      = 4'd2;
  localparam logic [PW-1:0] PhId        = 4'd3;
  localparam logic [PW-1:0] PhIdAfter   = 4'd4;
  localparam logic [PW-1:0] PhSkip      = 4'd5;
  localparam logic [PW-1:0] PhSize      = 4'd6;
  localparam logic [PW-1:0] PhPayload   = 4'd7;
  localparam logic [PW-1:0] PhPast      = 4'd8;
  localparam logic [PW-1:0] PhReject    = 4'd9;

  logic [ranicp_pkg::TagW-1:0] target_id;

  ranicp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .target_id_o (target_id)
  );

  // parse state
  logic [PW-1:0]                 phase_q, phase_d;
  logic [1:0]                    biw_q, biw_d;
  logic                          skip_q, skip_d;
  logic [31:0]                   asm_q, asm_d;
  logic [31:0]                   len_q, len_d;
  logic [ranicp_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]                   tag_q, tag_d;
  logic [ranicp_pkg::RemW-1:0]   rem_q, rem_d;
  logic                          seen_q, seen_d;

  // result register
  logic                          out_valid_q;
  logic [ranicp_pkg::KindW-1:0]  kind_q, kind_d;
  logic [31:0]                   otag_q, otag_d;
  logic [7:0]                    pay_q, pay_d;
  logic                          last_q, last_d;
  logic                          hit_q, hit_d;

  logic                          in_xfer;
  logic                          sof;
  logic [7:0]                    b;
  logic [PW-1:0]                 ph;
  logic [1:0]                    biw;
  logic [31:0]                   asm_w;
  logic [31:0]                   len;
  logic [ranicp_pkg::CntW-1:0]   cnt;
  logic [31:0]                   tag;
  logic [ranicp_pkg::RemW-1:0]   rem;
  logic                          seen;
  logic [ranicp_pkg::CntW-1:0]   end_mark;
  logic [31:0]                   asm_n;
  logic                          done;
  logic                          hit_raw;
  logic [ranicp_pkg::RemW-1:0]   padded;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign sof             = s_axis_tuser_i;
  assign b               = s_axis_tdata_i;

  always_comb begin
    // start of file clears the parse state in front of this byte
    ph    = sof ? PhRiff : phase_q;
    biw   = sof ? 2'd0 : biw_q;
    skip_d = sof ? 1'b0 : skip_q;
    asm_w = sof ? '0 : asm_q;
    len   = sof ? '0 : len_q;
    cnt   = sof ? '0 : cnt_q;
    tag   = sof ? '0 : tag_q;
    rem   = sof ? '0 : rem_q;
    seen  = sof ? 1'b0 : seen_q;

    end_mark = {2'b00, len} + ranicp_pkg::HdrExtra;
    if (ph == PhId && biw == 2'd0 && cnt >= end_mark) begin
      ph = PhPast;
    end

    phase_d = ph;
    biw_d   = biw;
    asm_d   = asm_w;
    len_d   = len;
    cnt_d   = cnt;
    tag_d   = tag;
    rem_d   = rem;
    seen_d  = seen;

    asm_n   = {b, asm_w[31:8]};
    done    = (biw == 2'd3);
    hit_raw = !seen && (tag == target_id);
    padded  = {1'b0, asm_n} + {{(ranicp_pkg::RemW-1){1'b0}}, asm_n[0]};

    kind_d = ranicp_pkg::KindRejected;
    otag_d = '0;
    pay_d  = '0;
    last_d = 1'b0;
    hit_d  = 1'b0;

    if (ph == PhPast) begin
      kind_d = ranicp_pkg::KindPastEnd;
    end else if (ph <= PhPayload) begin
      if (cnt != ranicp_pkg::CntMax) begin
        cnt_d = cnt + 1'b1;
      end
      if (ph != PhPayload) begin
        asm_d = asm_n;
        biw_d = biw + 2'd1;
      end
      unique case (ph)
        PhRiff: begin
          kind_d = ranicp_pkg::KindHeader;
          if (done) begin
            phase_d = (asm_n == ranicp_pkg::TagRiff) ? PhLen : PhReject;
          end
        end
        PhLen: begin
          kind_d = ranicp_pkg::KindHeader;
          if (done) begin
            len_d   = asm_n;
            phase_d = PhAcon;
          end
        end
        PhAcon: begin
          kind_d = ranicp_pkg::KindHeader;
          if (done) begin
            phase_d = (asm_n == ranicp_pkg::TagAcon) ? PhId : PhReject;
          end
        end
        PhId, PhIdAfter: begin
          kind_d = ranicp_pkg::KindChunkId;
          if (done) begin
            if (asm_n == ranicp_pkg::TagList) begin
              phase_d = PhSkip;
              skip_d  = 1'b0;
            end else begin
              tag_d   = asm_n;
              phase_d = PhSize;
            end
          end
        end
        PhSkip: begin
          kind_d = ranicp_pkg::KindListSkip;
          if (done) begin
            if (skip_d) begin
              skip_d  = 1'b0;
              phase_d = PhIdAfter;
            end else begin
              skip_d = 1'b1;
            end
          end
        end
        PhSize: begin
          kind_d = ranicp_pkg::KindSize;
          otag_d = tag;
          hit_d  = hit_raw;
          if (done) begin
            if (padded == '0) begin
              last_d  = 1'b1;
              seen_d  = seen || hit_raw;
              phase_d = PhId;
            end else begin
              rem_d   = padded;
              phase_d = PhPayload;
            end
          end
        end
        default: begin
          // payload byte, pad included
          kind_d = ranicp_pkg::KindPayload;
          otag_d = tag;
          pay_d  = b;
          hit_d  = hit_raw;
          if (rem <= {{(ranicp_pkg::RemW-1){1'b0}}, 1'b1}) begin
            rem_d   = '0;
            last_d  = 1'b1;
            seen_d  = seen || hit_raw;
            phase_d = PhId;
          end else begin
            rem_d = rem - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhRiff;
      biw_q   <= '0;
      skip_q  <= 1'b0;
      asm_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      tag_q   <= '0;
      rem_q   <= '0;
      seen_q  <= 1'b0;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      biw_q   <= biw_d;
      skip_q  <= skip_d;
      asm_q   <= asm_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= kind_d;
      otag_q <= otag_d;
      pay_q  <= pay_d;
      last_q <= last_d;
      hit_q  <= hit_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {pay_q, otag_q};
  assign m_axis_tuser_o  = {hit_q, kind_q};
  assign m_axis_tlast_o  = last_q;

endmodule
`default_nettype wire

// ----- sim/riff_ani_chunk_parser_checker.sv -----
// ----------------------------------------------------------------------------
// riff_ani_chunk_parser_checker
// Watches the byte stream, the result stream and the register port of the
// RIFF/ACON chunk parser. It keeps its own copy of the parse state, works out
// the classification of every accepted byte and compares each result transfer
// field by field with the oldest outstanding classification.
// ----------------------------------------------------------------------------
module riff_ani_chunk_parser_checker
  import ranicp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [7:0]        s_tdata_i,
  input  logic              s_tuser_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [39:0]       m_tdata_i,
  input  logic [3:0]        m_tuser_i,
  input  logic              m_tlast_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ApbAw-1:0]  paddr_i,
  input  logic [ApbDw-1:0]  pwdata_i,
  input  logic [ApbDw-1:0]  prdata_i,
  input  logic              pready_i,
  output int                errors_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ApbAw-1:0] TargetAddr = {RegTargetId, 2'b00};

  typedef enum logic [PhaseW-1:0] {
    PhRiff, PhLen, PhAcon, PhId, PhIdAfterList, PhSkip, PhSize, PhPayload, PhPast, PhReject
  } parse_phase_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  tag;
    logic [7:0]       pay;
    logic             last;
    logic             hit;
  } byte_class_t;

  parse_phase_e    phase;
  logic [1:0]      word_pos;
  logic            skip_second;
  logic [TagW-1:0] shift_word;
  logic [TagW-1:0] riff_len;
  logic [CntW-1:0] byte_count;
  logic [TagW-1:0] cur_tag;
  logic [RemW-1:0] pay_left;
  logic            target_done;
  logic [TagW-1:0] target_reg;

  byte_class_t class_q[$];
  int          n_err;
  int          n_checked;

  function automatic void clear_parse();
    phase       = PhRiff;
    word_pos    = '0;
    skip_second = 1'b0;
    shift_word  = '0;
    riff_len    = '0;
    byte_count  = '0;
    cur_tag     = '0;
    pay_left    = '0;
    target_done = 1'b0;
  endfunction

  function automatic byte_class_t classify_byte(input logic [7:0] b, input logic sof);
    byte_class_t     r;
    logic            done;
    logic [RemW-1:0] padded;
    r    = '{kind: KindRejected, tag: '0, pay: '0, last: 1'b0, hit: 1'b0};
    done = 1'b0;
    if (sof) clear_parse();
    // end test only before a fresh chunk id, never right after a list skip
    if (phase == PhId && word_pos == 2'd0 && byte_count >= ({2'b00, riff_len} + HdrExtra))
      phase = PhPast;
    if (phase == PhPast) begin
      r.kind = KindPastEnd;
    end else if (phase != PhReject) begin
      if (byte_count != CntMax) byte_count = byte_count + 1'b1;
      if (phase != PhPayload) begin
        shift_word = {b, shift_word[TagW-1:8]};
        word_pos   = word_pos + 2'd1;
        done       = (word_pos == 2'd0);
      end
      r.hit = !target_done && (cur_tag == target_reg);
      case (phase)
        PhRiff: begin
          r.kind = KindHeader;
          r.hit  = 1'b0;
          if (done) phase = (shift_word == TagRiff) ? PhLen : PhReject;
        end
        PhLen: begin
          r.kind = KindHeader;
          r.hit  = 1'b0;
          if (done) begin
            riff_len = shift_word;
            phase    = PhAcon;
          end
        end
        PhAcon: begin
          r.kind = KindHeader;
          r.hit  = 1'b0;
          if (done) phase = (shift_word == TagAcon) ? PhId : PhReject;
        end
        PhId, PhIdAfterList: begin
          r.kind = KindChunkId;
          r.hit  = 1'b0;
          if (done) begin
            if (shift_word == TagList) begin
              phase       = PhSkip;
              skip_second = 1'b0;
            end else begin
              cur_tag = shift_word;
              phase   = PhSize;
            end
          end
        end
        PhSkip: begin
          r.kind = KindListSkip;
          r.hit  = 1'b0;
          if (done) begin
            if (skip_second) begin
              skip_second = 1'b0;
              phase       = PhIdAfterList;
            end else begin
              skip_second = 1'b1;
            end
          end
        end
        PhSize: begin
          r.kind = KindSize;
          r.tag  = cur_tag;
          if (done) begin
            padded = {1'b0, shift_word} + {{TagW{1'b0}}, shift_word[0]};
            if (padded == '0) begin
              r.last = 1'b1;
              if (r.hit) target_done = 1'b1;
              phase = PhId;
            end else begin
              pay_left = padded;
              phase    = PhPayload;
            end
          end
        end
        PhPayload: begin
          r.kind = KindPayload;
          r.tag  = cur_tag;
          r.pay  = b;
          if (pay_left <= 1) begin
            pay_left = '0;
            r.last   = 1'b1;
            if (r.hit) target_done = 1'b1;
            phase = PhId;
          end else begin
            pay_left = pay_left - 1'b1;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    byte_class_t got;
    byte_class_t want;
    if (!rst_ni) begin
      clear_parse();
      target_reg = TagIcon;
      class_q.delete();
    end else begin
      // results first, so a result in the same cycle as its byte is caught
      if (m_tvalid_i && m_tready_i) begin
        got = '{kind: m_tuser_i[KindW-1:0], tag: m_tdata_i[31:0], pay: m_tdata_i[39:32],
                last: m_tlast_i, hit: m_tuser_i[3]};
        if (class_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result transfer, expected none, actual %0h", $time, got);
        end else begin
          want = class_q.pop_front();
          report_field("byte_kind", 32'(want.kind), 32'(got.kind));
          report_field("chunk_tag", want.tag, got.tag);
          report_field("payload_byte", 32'(want.pay), 32'(got.pay));
          report_field("chunk_last", 32'(want.last), 32'(got.last));
          report_field("target_hit", 32'(want.hit), 32'(got.hit));
          n_checked++;
        end
      end
      if (psel_i && penable_i && pready_i && paddr_i == TargetAddr) begin
        if (pwrite_i) target_reg = pwdata_i;
        else report_field("target_id readback", target_reg, prdata_i);
      end
      if (s_tvalid_i && s_tready_i) class_q.push_back(classify_byte(s_tdata_i, s_tuser_i));
    end
    errors_o  <= n_err;
    pending_o <= class_q.size();
    checked_o <= n_checked;
  end

endmodule

// ----- sim/riff_ani_chunk_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// riff_ani_chunk_parser_core_tb
// Feeds the RIFF/ACON chunk parser with two hand-built files and then with
// random files, mostly well formed with random chunk ids, sizes, list skips
// and length fields, the rest noise and damaged headers. The target id is
// rewritten between files and in the middle of some. Both stream sides stall
// at random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module riff_ani_chunk_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ranicp_pkg::*;

  localparam logic [ApbAw-1:0] TargetAddr = {RegTargetId, 2'b00};
  localparam int CycleLimit  = 200000;
  localparam int PhaseBytes  = 75;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [39:0]       m_tdata;
  logic [3:0]        m_tuser;
  logic              m_tlast;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ApbAw-1:0]  paddr     = '0;
  logic [ApbDw-1:0]  pwdata    = '0;
  logic [ApbDw-1:0]  prdata;
  logic              pready;

  int errors;
  int pending;
  int checked;

  bit          no_idle     = 1'b0;
  int          cycle_cnt   = 0;
  int          bytes_sent  = 0;
  int          files_sent  = 0;
  int          n_settings  = 0;
  logic [31:0] cur_target  = TagIcon;
  logic [7:0]  file_q[$];
  logic [7:0]  body_q[$];

  riff_ani_chunk_parser_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] data_byte
    .s_axis_tuser_i  (s_tuser),   // [0] start_of_file
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [31:0] chunk_tag, [39:32] payload_byte
    .m_axis_tuser_o  (m_tuser),   // [2:0] byte_kind, [3] target_hit
    .m_axis_tlast_o  (m_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  riff_ani_chunk_parser_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tlast_i  (m_tlast),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_i   (prdata),
    .pready_i   (pready),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 14);
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 14) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sof;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TargetAddr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cur_target = value;
    n_settings++;
  endtask

  task automatic apb_read();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TargetAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return cur_target;
      3:       return TagIcon;
      4, 5:    return TagList;
      6:       return 32'h0;
      7:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [31:0] w);
    for (int j = 0; j < 4; j++) body_q.push_back(w[8*j +: 8]);
  endtask

  task automatic retarget();
    logic [31:0] t;
    t = pick_id();
    wait_drain();
    apb_write(t);
    apb_read();
  endtask

  task automatic send_file(input bit with_sof, input int split_at);
    for (int i = 0; i < file_q.size(); i++) begin
      if (i == split_at) retarget();
      send_byte(file_q[i], with_sof && i == 0);
    end
    files_sent++;
  endtask

  task automatic build_file(output bit with_sof);
    int          mode;
    int          r;
    int          sz;
    int          chunk_len;
    bit          cut;
    logic [31:0] id;
    logic [31:0] len_w;
    logic [31:0] hdr[3];
    file_q.delete();
    body_q.delete();
    mode     = $urandom_range(0, 99);
    with_sof = ($urandom_range(0, 99) >= 4);
    if (mode < 8) begin
      repeat ($urandom_range(1, 8)) file_q.push_back(8'($urandom));
      return;
    end
    cut = 1'b0;
    for (int c = 0; c < $urandom_range(1, 4) && !cut; c++) begin
      do begin
        id = pick_id();
        push_word(id);
        if (id == TagList) repeat (8) body_q.push_back(8'($urandom));
      end while (id == TagList);
      if ($urandom_range(0, 99) < 90) begin
        sz = $urandom_range(0, 7);
        push_word(32'(sz));
        repeat (sz + (sz % 2)) body_q.push_back(8'($urandom));
      end else begin
        // huge chunk, cut short by the next file
        push_word(($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'($urandom));
        repeat ($urandom_range(1, 6)) body_q.push_back(8'($urandom));
        cut = 1'b1;
      end
    end
    chunk_len = body_q.size();
    if (!cut) repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 60)      len_w = 32'(4 + chunk_len);
    else if (r < 80) len_w = 32'(4 + chunk_len - int'($urandom_range(1, chunk_len)));
    else if (r < 90) len_w = 32'(4 + chunk_len + int'($urandom_range(1, 20)));
    else if (r < 95) len_w = 32'hFFFF_FFFF;
    else             len_w = $urandom;
    hdr[0] = TagRiff;
    hdr[1] = len_w;
    hdr[2] = TagAcon;
    if (mode < 13)      hdr[0] = hdr[0] ^ (32'd1 << $urandom_range(0, 31));
    else if (mode < 18) hdr[2] = hdr[2] ^ (32'd1 << $urandom_range(0, 31));
    foreach (hdr[k]) for (int j = 0; j < 4; j++) file_q.push_back(hdr[k][8*j +: 8]);
    foreach (body_q[k]) file_q.push_back(body_q[k]);
  endtask

  initial begin : stimulus
    logic [31:0] settings[6];
    bit          sof;
    int          phase_start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // register must read back its reset value
    apb_read();

    // small file: one target chunk with an odd size and pad, then past the end
    body_q.delete();
    push_word(TagRiff);
    push_word(32'd10);
    push_word(TagAcon);
    push_word(TagIcon);
    push_word(32'd1);
    body_q.push_back(8'hFF);
    body_q.push_back(8'h00);
    body_q.push_back(8'h00);
    file_q = body_q;
    send_file(1'b1, -1);
    // bad riff word, then a byte in the rejected state
    file_q = '{8'h52, 8'hFF, 8'h00, 8'h00, 8'hA5};
    send_file(1'b1, -1);

    settings = '{32'h0, 32'hFFFF_FFFF, TagIcon, $urandom, TagList, $urandom};
    foreach (settings[p]) begin
      wait_drain();
      apb_write(settings[p]);
      apb_read();
      no_idle     = (p == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        build_file(sof);
        send_file(sof, ($urandom_range(0, 99) < 6) ? int'($urandom_range(1, file_q.size())) - 1
                                                  : -1);
      end
    end
    no_idle = 1'b0;
    wait_drain();

    $display("sent %0d bytes in %0d files over %0d target id settings, %0d results checked",
             bytes_sent, files_sent, n_settings, checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
